>>> rtl/lcbc_pkg.sv
// Shared types and constants for the line crossing with border clamp block.
// No dependencies; every other file in rtl/ except lcbc_mul imports this package.
package lcbc_pkg;

  // Field widths fixed by the interface
  localparam int MODE_W     = 3;
  localparam int DIR_W      = 16;
  localparam int PT_W       = 16;
  localparam int DIM_W      = 13;
  localparam int CY_W       = 16;

  // Point format default: Q12.4 pixels
  localparam int COORD_BITS_DEF = 12;

  // Quotient bits kept by the divider; larger quotients only flag overflow
  localparam int DIV_QB     = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIM_W;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  // Fallback border codes
  localparam logic [MODE_W-1:0] MODE_TOP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BOTTOM = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd4;

  // Divider status back to the sequencer
  typedef struct packed {
    logic done;
    logic ovf;     // quotient magnitude >= 2**DIV_QB
    logic rem_nz;  // remainder nonzero
    logic neg;     // quotient sign
  } div_stat_t;

endpackage

>>> rtl/lcbc_in_if.sv
// Input channel: valid/ready handshake carrying one pair of lines per word.
// Depends on lcbc_pkg.
interface lcbc_in_if;
  import lcbc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DIR_W-1:0]  line1_dir_x;
  logic signed [DIR_W-1:0]  line1_dir_y;
  logic [PT_W-1:0]          line1_pt_x;
  logic [PT_W-1:0]          line1_pt_y;
  logic signed [DIR_W-1:0]  line2_dir_x;
  logic signed [DIR_W-1:0]  line2_dir_y;
  logic [PT_W-1:0]          line2_pt_x;
  logic [PT_W-1:0]          line2_pt_y;

  modport source (
    output valid, mode, line1_dir_x, line1_dir_y, line1_pt_x, line1_pt_y,
           line2_dir_x, line2_dir_y, line2_pt_x, line2_pt_y,
    input  ready
  );

  modport sink (
    input  valid, mode, line1_dir_x, line1_dir_y, line1_pt_x, line1_pt_y,
           line2_dir_x, line2_dir_y, line2_pt_x, line2_pt_y,
    output ready
  );

endinterface

>>> rtl/lcbc_out_if.sv
// Result channel: valid/ready handshake carrying one crossing word.
// Depends on lcbc_pkg.
interface lcbc_out_if;
  import lcbc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [DIM_W-1:0]        cross_x;
  logic signed [CY_W-1:0]  cross_y;
  logic                    found_inside;
  logic                    degenerate;

  modport source (
    output valid, cross_x, cross_y, found_inside, degenerate,
    input  ready
  );

  modport sink (
    input  valid, cross_x, cross_y, found_inside, degenerate,
    output ready
  );

endinterface

>>> rtl/lcbc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on nothing; operands are chosen by the sequencer in the top level.
module lcbc_mul #(
  parameter int A_W = 32,
  parameter int B_W = 22
) (
  input  logic                        clk,
  input  logic signed [A_W-1:0]       a,
  input  logic signed [B_W-1:0]       b,
  output logic signed [A_W+B_W-1:0]   prod
);

  logic signed [A_W+B_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

  assign prod = prod_r;

endmodule

>>> rtl/lcbc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, truncating toward zero.
// Keeps DIV_QB quotient bits and flags larger quotients. Depends on lcbc_pkg.
module lcbc_div #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]            den,
  input  logic                        den_neg,
  output logic [lcbc_pkg::DIV_QB-1:0] q,
  output lcbc_pkg::div_stat_t         stat
);
  import lcbc_pkg::*;

  localparam int RW    = ((NUM_W > DEN_W + DIV_QB) ? NUM_W : DEN_W + DIV_QB) + 1;
  localparam int CNT_W = $clog2(DIV_QB);

  logic [RW-1:0]      rem_r;
  logic [RW-1:0]      dsh_r;
  logic [DEN_W-1:0]   den_r;
  logic [DIV_QB-1:0]  q_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               first_r;
  logic               done_r;
  logic               ovf_r;
  logic               neg_r;
  logic [NUM_W-1:0]   num_abs;
  logic               ge;

  assign num_abs = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
  assign ge      = (rem_r >= dsh_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      first_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r  <= 1'b0;
      first_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        first_r <= 1'b1;
        cnt_r   <= CNT_W'(DIV_QB - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= RW'(num_abs);
      dsh_r <= RW'(den) << (DIV_QB - 1);
      den_r <= den;
      neg_r <= num[NUM_W-1] ^ den_neg;
    end else if (busy_r) begin
      if (first_r) begin
        ovf_r <= (rem_r >= (RW'(den_r) << DIV_QB));
      end
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[DIV_QB-2:0], ge};
    end
  end

  assign q           = q_r;
  assign stat.done   = done_r;
  assign stat.ovf    = ovf_r;
  assign stat.rem_nz = |rem_r;
  assign stat.neg    = neg_r;

endmodule

>>> rtl/line_crossing_with_border_clamp.sv
// Line crossing with border clamp: sequencer over one shared multiplier and one divider.
// Path: a vertical line skips the products and divides; other words need up to two divides,
//   which take turns on the shared divider, with products from the shared multiplier.
// Throughput: one word at a time; the next word is taken once the result sits in the
//   output register, which holds it until the sink takes it.
// Reset: synchronous active-low; image width 640, height 480, sequencer idle, output empty.
module line_crossing_with_border_clamp #(
  parameter int COORD_BITS = lcbc_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lcbc_in_if.sink                         in_ch,
  lcbc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lcbc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lcbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lcbc_pkg::*;

  localparam int FRAC_W = PT_W - COORD_BITS;
  localparam int GW     = ((DIM_W + FRAC_W > PT_W) ? DIM_W + FRAC_W : PT_W) + 1;
  localparam int MAW    = 2 * DIR_W;
  localparam int MPW    = MAW + GW;
  localparam int ACC_W  = MPW + 2;
  localparam int C_W    = MAW + 1;
  localparam int DVW    = MAW + FRAC_W;
  localparam int VS_W   = DIV_QB + 2;
  localparam logic signed [VS_W-1:0] CY_MAX = VS_W'((2 ** (CY_W - 1)) - 1);
  localparam logic signed [VS_W-1:0] CY_MIN = -CY_MAX - VS_W'(1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_P1    = 5'd1;
  localparam logic [4:0] S_P2    = 5'd2;
  localparam logic [4:0] S_P3    = 5'd3;
  localparam logic [4:0] S_P4    = 5'd4;
  localparam logic [4:0] S_P5    = 5'd5;
  localparam logic [4:0] S_P6    = 5'd6;
  localparam logic [4:0] S_P7    = 5'd7;
  localparam logic [4:0] S_SDIV1 = 5'd8;
  localparam logic [4:0] S_WDIV1 = 5'd9;
  localparam logic [4:0] S_FB    = 5'd10;
  localparam logic [4:0] S_G1    = 5'd11;
  localparam logic [4:0] S_G2    = 5'd12;
  localparam logic [4:0] S_GACC  = 5'd13;
  localparam logic [4:0] S_SDIV2 = 5'd14;
  localparam logic [4:0] S_WDIV2 = 5'd15;
  localparam logic [4:0] S_FIN   = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0]               state_r, state_nxt;
  logic [DIM_W-1:0]         w_r, h_r;

  logic [MODE_W-1:0]        mode_r;
  logic signed [DIR_W-1:0]  vx1_r, vy1_r, vx2_r, vy2_r;
  logic [PT_W-1:0]          px1_r, py1_r, px2_r;
  logic signed [PT_W:0]     dy_r;

  logic signed [MAW-1:0]    pa_r, pb_r, pc_r;
  logic signed [C_W-1:0]    c_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [GW-1:0]     g_r;
  logic [DIM_W-1:0]         xi_r;
  logic                     ypath_r;
  logic                     found_r;
  logic signed [VS_W-1:0]   vs_r;

  logic [DIM_W-1:0]         res_cx_r;
  logic signed [CY_W-1:0]   res_cy_r;
  logic                     res_deg_r;

  logic                     out_valid_r;
  logic [DIM_W-1:0]         out_cx_r;
  logic signed [CY_W-1:0]   out_cy_r;
  logic                     out_found_r;
  logic                     out_deg_r;

  logic                     in_acc;
  logic                     out_free;
  logic                     degen;
  logic signed [MAW-1:0]    mul_a;
  logic signed [GW-1:0]     mul_b;
  logic signed [MPW-1:0]    mul_p;
  logic                     div_start;
  logic [DVW-1:0]           div_den;
  logic                     div_den_neg;
  logic [DIV_QB-1:0]        div_q;
  div_stat_t                div_stat;
  logic [C_W-1:0]           c_abs;
  logic [DIR_W-1:0]         vx1_abs, vy1_abs;
  logic [DIV_QB:0]          q_inc;
  logic                     found_cond;
  logic [VS_W-1:0]          vs_mag;
  logic signed [VS_W-1:0]   y_cl;
  logic signed [CY_W-1:0]   y_sat;
  logic signed [VS_W-1:0]   h_s, w_s;
  logic [DIM_W-1:0]         x_cl;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign degen    = (vx1_r == '0) || (vx2_r == '0);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= WIDTH_RESET;
      h_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH:  w_r <= cfg_wdata;
        REG_IMAGE_HEIGHT: h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_P1: begin mul_a = MAW'(vy1_r); mul_b = GW'(vx2_r); end
      S_P2: begin mul_a = MAW'(vy2_r); mul_b = GW'(vx1_r); end
      S_P3: begin mul_a = MAW'(vx1_r); mul_b = GW'(vx2_r); end
      S_P4: begin mul_a = pa_r;        mul_b = GW'(px1_r); end
      S_P5: begin mul_a = pb_r;        mul_b = GW'(px2_r); end
      S_P6: begin mul_a = pc_r;        mul_b = GW'(dy_r);  end
      S_G1: begin
        mul_a = ypath_r ? MAW'(vx1_r) : MAW'(vy1_r);
        mul_b = ypath_r ? GW'(py1_r)  : GW'(px1_r);
      end
      S_G2: begin
        mul_a = ypath_r ? MAW'(vy1_r) : MAW'(vx1_r);
        mul_b = g_r;
      end
      default: ;
    endcase
  end

  lcbc_mul #(.A_W(MAW), .B_W(GW)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_p)
  );

  // divider operands: crossing search divides B by C, line evaluation by the direction
  assign c_abs   = c_r[C_W-1] ? $unsigned(-c_r) : $unsigned(c_r);
  assign vx1_abs = vx1_r[DIR_W-1] ? $unsigned(-vx1_r) : $unsigned(vx1_r);
  assign vy1_abs = vy1_r[DIR_W-1] ? $unsigned(-vy1_r) : $unsigned(vy1_r);

  always_comb begin
    if (state_r == S_SDIV1) begin
      div_den     = {c_abs[MAW-1:0], {FRAC_W{1'b0}}};
      div_den_neg = c_r[C_W-1];
    end else if (ypath_r) begin
      div_den     = DVW'({vx1_abs, {FRAC_W{1'b0}}});
      div_den_neg = vx1_r[DIR_W-1];
    end else begin
      div_den     = DVW'({vy1_abs, {FRAC_W{1'b0}}});
      div_den_neg = vy1_r[DIR_W-1];
    end
  end

  assign div_start = ((state_r == S_SDIV1) && (c_r != '0)) || (state_r == S_SDIV2);

  lcbc_div #(.NUM_W(ACC_W), .DEN_W(DVW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num     (acc_r),
    .den     (div_den),
    .den_neg (div_den_neg),
    .q       (div_q),
    .stat    (div_stat)
  );

  // root of d(x) = C*s*x + B lies strictly inside (x-1, x) with x = floor(-B/(C*s)) + 1
  assign q_inc      = {1'b0, div_q} + (DIV_QB+1)'(1);
  assign found_cond = div_stat.neg && div_stat.rem_nz && !div_stat.ovf &&
                      (q_inc < (DIV_QB+1)'(w_r));

  assign vs_mag = div_stat.ovf ? {2'b01, {DIV_QB{1'b0}}} : {2'b00, div_q};

  // result shaping
  assign h_s = $signed(VS_W'(h_r));
  assign w_s = $signed(VS_W'(w_r));

  always_comb begin
    if (found_r) begin
      y_cl = vs_r;
    end else if (mode_r == MODE_LEFT) begin
      y_cl = (vs_r < 0) ? '0 : vs_r;
    end else begin
      y_cl = (vs_r > h_s) ? h_s : vs_r;
    end
  end

  assign y_sat = (y_cl > CY_MAX) ? CY_W'(CY_MAX) :
                 (y_cl < CY_MIN) ? CY_W'(CY_MIN) : y_cl[CY_W-1:0];
  assign x_cl  = (vs_r < 0) ? '0 : (vs_r > w_s) ? w_r : vs_r[DIM_W-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_P1;
      S_P1:    state_nxt = degen ? S_DONE : S_P2;
      S_P2:    state_nxt = S_P3;
      S_P3:    state_nxt = S_P4;
      S_P4:    state_nxt = S_P5;
      S_P5:    state_nxt = S_P6;
      S_P6:    state_nxt = S_P7;
      S_P7:    state_nxt = S_SDIV1;
      S_SDIV1: state_nxt = (c_r == '0) ? S_FB : S_WDIV1;
      S_WDIV1: if (div_stat.done) state_nxt = found_cond ? S_G1 : S_FB;
      S_FB: begin
        case (mode_r) inside
          MODE_LEFT, MODE_RIGHT:  state_nxt = S_G1;
          MODE_TOP, MODE_BOTTOM:  state_nxt = (vy1_r == '0) ? S_DONE : S_G1;
          default:                state_nxt = S_DONE;
        endcase
      end
      S_G1:    state_nxt = S_G2;
      S_G2:    state_nxt = S_GACC;
      S_GACC:  state_nxt = S_SDIV2;
      S_SDIV2: state_nxt = S_WDIV2;
      S_WDIV2: if (div_stat.done) state_nxt = S_FIN;
      S_FIN:   state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_r <= in_ch.mode;
          vx1_r  <= in_ch.line1_dir_x;
          vy1_r  <= in_ch.line1_dir_y;
          px1_r  <= in_ch.line1_pt_x;
          py1_r  <= in_ch.line1_pt_y;
          vx2_r  <= in_ch.line2_dir_x;
          vy2_r  <= in_ch.line2_dir_y;
          px2_r  <= in_ch.line2_pt_x;
          dy_r   <= $signed({1'b0, in_ch.line1_pt_y}) - $signed({1'b0, in_ch.line2_pt_y});
        end
      end
      S_P1: begin
        found_r   <= 1'b0;
        res_deg_r <= degen;
        res_cx_r  <= '0;
        res_cy_r  <= '0;
      end
      S_P2: pa_r <= MAW'(mul_p);
      S_P3: pb_r <= MAW'(mul_p);
      S_P4: begin
        pc_r <= MAW'(mul_p);
        c_r  <= C_W'(pa_r) - C_W'(pb_r);
      end
      // B = vx1*vx2*(py1-py2) - vy1*vx2*px1 + vy2*vx1*px2
      S_P5: acc_r <= -ACC_W'(mul_p);
      S_P6: acc_r <= acc_r + ACC_W'(mul_p);
      S_P7: acc_r <= acc_r + ACC_W'(mul_p);
      S_WDIV1: begin
        if (div_stat.done && found_cond) begin
          found_r <= 1'b1;
          ypath_r <= 1'b1;
          xi_r    <= q_inc[DIM_W-1:0];
        end
      end
      S_FB: begin
        case (mode_r) inside
          MODE_LEFT, MODE_RIGHT: begin
            ypath_r <= 1'b1;
            xi_r    <= w_r;
          end
          MODE_TOP, MODE_BOTTOM: begin
            ypath_r  <= 1'b0;
            res_cx_r <= '0;
            res_cy_r <= (mode_r == MODE_TOP) ? '0 : CY_W'(h_r);
          end
          default: begin
            res_cx_r <= '0;
            res_cy_r <= '0;
          end
        endcase
      end
      S_G1: begin
        if (ypath_r) begin
          g_r <= GW'({xi_r, {FRAC_W{1'b0}}}) - GW'(py1_r == py1_r ? px1_r : px1_r);
        end else if (mode_r == MODE_TOP) begin
          g_r <= -GW'(py1_r);
        end else begin
          g_r <= GW'({h_r, {FRAC_W{1'b0}}}) - GW'(py1_r);
        end
      end
      S_G2:   acc_r <= ACC_W'(mul_p);
      S_GACC: acc_r <= acc_r + ACC_W'(mul_p);
      S_WDIV2: begin
        if (div_stat.done) begin
          vs_r <= div_stat.neg ? -$signed(vs_mag) : $signed(vs_mag);
        end
      end
      S_FIN: begin
        if (ypath_r) begin
          res_cx_r <= xi_r;
          res_cy_r <= y_sat;
        end else begin
          res_cx_r <= x_cl;
          res_cy_r <= (mode_r == MODE_TOP) ? '0 : CY_W'(h_r);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_cx_r    <= res_cx_r;
          out_cy_r    <= res_cy_r;
          out_found_r <= found_r;
          out_deg_r   <= res_deg_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.cross_x      = out_cx_r;
  assign out_ch.cross_y      = out_cy_r;
  assign out_ch.found_inside = out_found_r;
  assign out_ch.degenerate   = out_deg_r;

endmodule

>>> tb/lcbc_crossing_monitor.sv
`timescale 1ns / 1ps
// Crossing monitor: watches the line-pair and result channels plus the register port,
// predicts every result word and compares it. Depends on lcbc_pkg and the channel interfaces.
module lcbc_crossing_monitor
  import lcbc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lcbc_in_if                    in_ch,
  lcbc_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    crossings
);

  localparam longint PT_SCALE = longint'(1) << (PT_W - COORD_BITS);

  typedef struct packed {
    logic [DIM_W-1:0] cross_x;
    logic [CY_W-1:0]  cross_y;
    logic             found_inside;
    logic             degenerate;
  } crossing_t;

  crossing_t        expected_crossings[$];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  int               errs;
  int               n_checked;
  int               n_cross;

  // y of line 1 at integer x, truncated toward zero
  function automatic longint line_y_at(longint x, longint vx, longint vy, longint px,
                                       longint py);
    return (py * vx + vy * (x * PT_SCALE - px)) / (PT_SCALE * vx);
  endfunction

  function automatic crossing_t predict_crossing(
    input logic [MODE_W-1:0]       mode,
    input logic signed [DIR_W-1:0] l1_dx, l1_dy,
    input logic [PT_W-1:0]         l1_px, l1_py,
    input logic signed [DIR_W-1:0] l2_dx, l2_dy,
    input logic [PT_W-1:0]         l2_px, l2_py,
    input logic [DIM_W-1:0]        w_reg, h_reg
  );
    longint    vx1, vy1, px1, py1, vx2, vy2, px2, py2;
    longint    w, h, t, d, prev, x, num, cx, cy;
    bit        hit;
    crossing_t res;
    vx1 = l1_dx; vy1 = l1_dy; px1 = l1_px; py1 = l1_py;
    vx2 = l2_dx; vy2 = l2_dy; px2 = l2_px; py2 = l2_py;
    w = w_reg;
    h = h_reg;
    res = '0;
    if (vx1 == 0 || vx2 == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    // exact sign scan, everything scaled by PT_SCALE*vx1*vx2; a zero resets the history
    hit = 1'b0;
    prev = 0;
    x = 0;
    while (!hit && x < w) begin
      t = x * PT_SCALE;
      d = vy1 * vx2 * (t - px1) - vy2 * vx1 * (t - px2) + vx1 * vx2 * (py1 - py2);
      if ((d < 0 && prev > 0) || (d > 0 && prev < 0)) begin
        hit = 1'b1;
      end else begin
        prev = d;
        x++;
      end
    end
    cx = 0;
    cy = 0;
    if (hit) begin
      cx = x;
      cy = line_y_at(x, vx1, vy1, px1, py1);
    end else if (mode == MODE_TOP || mode == MODE_BOTTOM) begin
      if (vy1 != 0) begin
        num = (mode == MODE_TOP) ? px1 * vy1 - py1 * vx1
                                 : px1 * vy1 + (h * PT_SCALE - py1) * vx1;
        cx = num / (PT_SCALE * vy1);
        if (cx < 0) cx = 0;
        if (cx > w) cx = w;
      end
      cy = (mode == MODE_TOP) ? 0 : h;
    end else if (mode == MODE_LEFT || mode == MODE_RIGHT) begin
      num = line_y_at(w, vx1, vy1, px1, py1);
      cx = w;
      if (mode == MODE_LEFT) cy = (num < 0) ? 0 : num;
      else cy = (num > h) ? h : num;
    end
    if (cy < -32768) cy = -32768;
    if (cy > 32767) cy = 32767;
    res.cross_x = cx[DIM_W-1:0];
    res.cross_y = cy[CY_W-1:0];
    res.found_inside = hit;
    return res;
  endfunction

  function automatic void compare_field(string name, logic signed [CY_W:0] want_v,
                                        logic signed [CY_W:0] got_v);
    if (got_v !== want_v) begin
      errs++;
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
    end
  endfunction

  initial begin
    errs = 0;
    n_checked = 0;
    n_cross = 0;
  end

  always @(posedge clk) begin : track
    crossing_t want;
    if (!rst_n) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      expected_crossings.delete();
    end else begin
      // retire the oldest expectation before queuing a new one
      if (out_ch.valid && out_ch.ready) begin
        if (expected_crossings.size() == 0) begin
          errs++;
          $error("result word with nothing expected: cross_x %0d cross_y %0d",
                 out_ch.cross_x, out_ch.cross_y);
        end else begin
          want = expected_crossings.pop_front();
          compare_field("cross_x", want.cross_x, out_ch.cross_x);
          compare_field("cross_y", $signed(want.cross_y), out_ch.cross_y);
          compare_field("found_inside", want.found_inside, out_ch.found_inside);
          compare_field("degenerate", want.degenerate, out_ch.degenerate);
          n_checked++;
          if (want.found_inside) n_cross++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_crossings.push_back(predict_crossing(
          in_ch.mode,
          in_ch.line1_dir_x, in_ch.line1_dir_y, in_ch.line1_pt_x, in_ch.line1_pt_y,
          in_ch.line2_dir_x, in_ch.line2_dir_y, in_ch.line2_pt_x, in_ch.line2_pt_y,
          width_reg, height_reg));
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_IMAGE_WIDTH:  width_reg  = cfg_wdata;
          REG_IMAGE_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end
    end
    fail_count <= errs;
    pending    <= expected_crossings.size();
    checked    <= n_checked;
    crossings  <= n_cross;
  end

endmodule

>>> tb/line_crossing_with_border_clamp_tb.sv
`timescale 1ns / 1ps
// Top of the line crossing testbench: clock, reset, line-pair stimulus, result-side stalls
// and the verdict. Depends on lcbc_pkg, the channel interfaces and lcbc_crossing_monitor.
module line_crossing_with_border_clamp_tb;
  import lcbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_PHASES       = 9;
  localparam logic [MODE_W-1:0] BORDER_MODES [4] = '{MODE_TOP, MODE_BOTTOM, MODE_LEFT,
                                                      MODE_RIGHT};
  // codes with no fallback border
  localparam logic [MODE_W-1:0] UNDEFINED_MODES [4] = '{3'd0, 3'd5, 3'd6, 3'd7};

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic signed [DIR_W-1:0] dx1, dy1;
    logic [PT_W-1:0]         px1, py1;
    logic signed [DIR_W-1:0] dx2, dy2;
    logic [PT_W-1:0]         px2, py2;
  } line_pair_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    checked;
  int                    crossings;
  int                    idle_pct = 25;
  int                    pairs_sent = 0;

  lcbc_in_if  in_bus ();
  lcbc_out_if out_bus ();

  line_crossing_with_border_clamp uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  lcbc_crossing_monitor crossing_mon (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .crossings  (crossings)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic line_pair_t mk_pair(logic [MODE_W-1:0] m, int dx1, int dy1, int px1,
                                         int py1, int dx2, int dy2, int px2, int py2);
    line_pair_t p;
    p.mode = m;
    p.dx1 = dx1; p.dy1 = dy1; p.px1 = px1; p.py1 = py1;
    p.dx2 = dx2; p.dy2 = dy2; p.px2 = px2; p.py2 = py2;
    return p;
  endfunction

  function automatic int any_dir();
    int v;
    v = $urandom_range(0, 32768);
    return v - 16384;
  endfunction

  // nonzero x component; now and then a tiny one for very steep lines
  function automatic int run_dir();
    int v;
    v = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16384);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic int clip_pt(int v);
    return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    if ($urandom_range(0, 99) < 85) return BORDER_MODES[$urandom_range(0, 3)];
    return UNDEFINED_MODES[$urandom_range(0, 3)];
  endfunction

  function automatic line_pair_t random_pair(int w, int h);
    line_pair_t p;
    int         kind, span_x, span_y, xc, yc, a1, a2, vx1, vy1, vx2, vy2;
    kind   = $urandom_range(0, 99);
    span_x = (w < 1) ? 16 : (w * 16 > 65535) ? 65535 : w * 16;
    span_y = (h * 16 > 65535) ? 65535 : h * 16;
    xc = $urandom_range(0, span_x);
    yc = $urandom_range(0, span_y);
    a1 = $urandom_range(0, 6400);
    a1 = a1 - 3200;
    a2 = $urandom_range(0, 6400);
    a2 = a2 - 3200;
    vx1 = run_dir();
    vy1 = any_dir();
    vx2 = run_dir();
    vy2 = any_dir();
    // two lines through a common point inside the image
    p = mk_pair(pick_mode(), vx1, vy1, clip_pt(xc + a1 * vx1 / 16384),
                clip_pt(yc + a1 * vy1 / 16384), vx2, vy2,
                clip_pt(xc + a2 * vx2 / 16384), clip_pt(yc + a2 * vy2 / 16384));
    if (kind >= 60 && kind < 70) begin
      p.dx2 = $urandom_range(0, 1) ? -vx1 : vx1;
      p.dy2 = (p.dx2 == vx1) ? vy1 : -vy1;
    end else if (kind >= 70 && kind < 78) begin
      case ($urandom_range(0, 2))
        0: p.dx1 = '0;
        1: p.dx2 = '0;
        default: begin
          p.dx1 = '0;
          p.dx2 = '0;
        end
      endcase
    end else if (kind >= 78 && kind < 86) begin
      p.dy1 = '0;
      if ($urandom_range(0, 1)) p.dy2 = '0;
    end else if (kind >= 86) begin
      p = mk_pair(3'($urandom_range(0, 7)), any_dir(), any_dir(), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), any_dir(), any_dir(), $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
    end
    return p;
  endfunction

  task automatic send_pair(line_pair_t p);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.mode        <= p.mode;
    in_bus.line1_dir_x <= p.dx1;
    in_bus.line1_dir_y <= p.dy1;
    in_bus.line1_pt_x  <= p.px1;
    in_bus.line1_pt_y  <= p.py1;
    in_bus.line2_dir_x <= p.dx2;
    in_bus.line2_dir_y <= p.dy2;
    in_bus.line2_pt_x  <= p.px2;
    in_bus.line2_pt_y  <= p.py2;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pairs_sent++;
  endtask

  // hold the sender until every expected result word is back
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_geometry(int w, int h);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx   <= REG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // result side: random stall bursts
  initial begin : result_sink
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("line_crossing_with_border_clamp test failed");
    $finish;
  end

  initial begin : stimulus
    int w, h, n;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= REG_IMAGE_WIDTH;
    cfg_wdata          <= '0;
    out_bus.ready      <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.mode        <= MODE_TOP;
    in_bus.line1_dir_x <= '0;
    in_bus.line1_dir_y <= '0;
    in_bus.line1_pt_x  <= '0;
    in_bus.line1_pt_y  <= '0;
    in_bus.line2_dir_x <= '0;
    in_bus.line2_dir_y <= '0;
    in_bus.line2_pt_x  <= '0;
    in_bus.line2_pt_y  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at the reset geometry, 640 x 480
    send_pair(mk_pair(MODE_TOP, 0, 16384, 1600, 1600, 16384, 0, 0, 0));
    send_pair(mk_pair(MODE_RIGHT, 16384, 16384, 0, 0, 0, -16384, 65535, 65535));
    send_pair(mk_pair(UNDEFINED_MODES[0], 0, 0, 0, 0, 0, 0, 0, 0));
    // crossing exactly on a pixel: the zero there hides the sign change
    send_pair(mk_pair(MODE_TOP, 16384, 16384, 0, 0, 16384, -16384, 1600, 0));
    send_pair(mk_pair(MODE_BOTTOM, 16384, 16384, 0, 0, 16384, -16384, 1616, 0));
    send_pair(mk_pair(MODE_LEFT, 16384, 16384, 0, 0, 16384, -16384, 16, 0));
    send_pair(mk_pair(MODE_LEFT, 16384, 8192, 0, 1600, 16384, 16384, 0, 2400));
    foreach (BORDER_MODES[i])
      send_pair(mk_pair(BORDER_MODES[i], 16384, 8192, 0, 1600, -16384, -8192, 160, 3200));
    send_pair(mk_pair(MODE_TOP, 16384, 0, 320, 800, -16384, 0, 0, 1600));
    send_pair(mk_pair(MODE_BOTTOM, 16384, 0, 320, 800, -16384, 0, 0, 1600));
    send_pair(mk_pair(UNDEFINED_MODES[1], 16384, 8192, 0, 1600, 16384, 8192, 0, 3200));
    send_pair(mk_pair(UNDEFINED_MODES[3], 16384, 16384, 0, 0, 16384, -16384, 1616, 0));
    send_pair(mk_pair(MODE_RIGHT, -16384, -16384, 65535, 65535, -16384, 16384, 65535, 0));
    // near-vertical lines drive y into saturation
    send_pair(mk_pair(MODE_LEFT, 1, 16384, 0, 0, 1, 16384, 0, 16));
    send_pair(mk_pair(MODE_RIGHT, 1, -16384, 0, 65535, 1, -16384, 0, 65519));
    send_pair(mk_pair(MODE_LEFT, 16384, -16384, 0, 1600, 16384, -16384, 0, 3200));
    send_pair(mk_pair(MODE_RIGHT, 16384, 16384, 0, 1600, 16384, 16384, 0, 0));
    send_pair(mk_pair(MODE_TOP, 16384, -1, 0, 1600, 16384, -1, 0, 0));
    send_pair(mk_pair(MODE_BOTTOM, 1, 1, 65535, 65535, 1, -1, 0, 0));
    send_pair(mk_pair(MODE_TOP, -16384, 16384, 8000, 0, 16384, 16384, 0, 4000));

    for (int ph = 0; ph < N_PHASES; ph++) begin
      n = 70;
      case (ph)
        0: begin
          w = 0;
          h = 480;
          n = 20;
        end
        1: begin
          w = 1;
          h = 1;
          n = 20;
        end
        2: begin
          w = 4096;
          h = 4096;
        end
        3: begin
          w = 640;
          h = 480;
        end
        default: begin
          w = $urandom_range(1, 4096);
          h = $urandom_range(1, 4096);
        end
      endcase
      drain_results();
      set_geometry(w, h);
      idle_pct = (ph == N_PHASES - 1) ? 0 : (ph % 3 == 1) ? 10 : 35;
      repeat (n) send_pair(random_pair(w, h));
    end

    drain_results();
    repeat (64) @(posedge clk);
    $display("Sent %0d line pairs over %0d image geometries (zero width to 4096).",
             pairs_sent, N_PHASES + 1);
    $display("Checked %0d result words, %0d with a crossing found inside the scan.",
             checked, crossings);
    if (fail_count == 0)
      $display("line_crossing_with_border_clamp test passed");
    else
      $display("line_crossing_with_border_clamp test failed");
    $finish;
  end

endmodule

>>> line_crossing_with_border_clamp.f
rtl/lcbc_pkg.sv
rtl/lcbc_in_if.sv
rtl/lcbc_out_if.sv
rtl/lcbc_mul.sv
rtl/lcbc_div.sv
rtl/line_crossing_with_border_clamp.sv
tb/lcbc_crossing_monitor.sv
tb/line_crossing_with_border_clamp_tb.sv
